### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### src/sll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer package
// Beat types, token kinds, scan modes and the keyword and symbol lookups.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int COLUMN_LIMIT_DEF       = 16384;
  localparam int TOKEN_LENGTH_LIMIT_DEF = 63;
  localparam int QUEUE_DEPTH            = 4;

  // Scan modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_COLON   = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  // Token kinds
  localparam logic [4:0] KIND_ASSIGN = 5'd8;
  localparam logic [4:0] KIND_EQ     = 5'd9;
  localparam logic [4:0] KIND_LT     = 5'd10;
  localparam logic [4:0] KIND_PLUS   = 5'd11;
  localparam logic [4:0] KIND_MINUS  = 5'd12;
  localparam logic [4:0] KIND_STAR   = 5'd13;
  localparam logic [4:0] KIND_SLASH  = 5'd14;
  localparam logic [4:0] KIND_CARET  = 5'd15;
  localparam logic [4:0] KIND_SEMI   = 5'd16;
  localparam logic [4:0] KIND_LPAREN = 5'd17;
  localparam logic [4:0] KIND_RPAREN = 5'd18;
  localparam logic [4:0] KIND_LBRACE = 5'd19;
  localparam logic [4:0] KIND_RBRACE = 5'd20;
  localparam logic [4:0] KIND_IDENT  = 5'd21;
  localparam logic [4:0] KIND_NUMBER = 5'd22;

  // Characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_beat_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [13:0] start_column;
    logic [5:0]  token_length;
    logic        run_end;
  } token_beat_t;

  // Up to two tokens from one text beat, first one in slot a
  typedef struct packed {
    logic        valid_a;
    logic        valid_b;
    token_beat_t beat_a;
    token_beat_t beat_b;
  } scan_result_t;

  typedef struct packed {
    logic [2:0] fill;
  } queue_status_t;

  function automatic logic is_word_char(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit_char(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Keywords, bytes packed little endian; returns {hit, kind}
  function automatic logic [5:0] kw_lookup(logic [47:0] word_bytes, logic [2:0] len);
    logic [5:0] r;
    r = {1'b0, KIND_IDENT};
    case (len)
      3'd2: if (word_bytes == 48'h6669) r = {1'b1, 5'd0};
      3'd3: if (word_bytes == 48'h646e65) r = {1'b1, 5'd3};
      3'd4: begin
        if (word_bytes == 48'h6e656874) r = {1'b1, 5'd1};
        else if (word_bytes == 48'h65736c65) r = {1'b1, 5'd2};
        else if (word_bytes == 48'h64616572) r = {1'b1, 5'd6};
      end
      3'd5: begin
        if (word_bytes == 48'h6c69746e75) r = {1'b1, 5'd5};
        else if (word_bytes == 48'h6574697277) r = {1'b1, 5'd7};
      end
      3'd6: if (word_bytes == 48'h746165706572) r = {1'b1, 5'd4};
      default: r = {1'b0, KIND_IDENT};
    endcase
    return r;
  endfunction

  // Single-character symbols; returns {hit, kind}
  function automatic logic [5:0] sym_lookup(logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h3D:   r = {1'b1, KIND_EQ};
      8'h3C:   r = {1'b1, KIND_LT};
      8'h2B:   r = {1'b1, KIND_PLUS};
      8'h2D:   r = {1'b1, KIND_MINUS};
      8'h2A:   r = {1'b1, KIND_STAR};
      8'h2F:   r = {1'b1, KIND_SLASH};
      8'h5E:   r = {1'b1, KIND_CARET};
      8'h3B:   r = {1'b1, KIND_SEMI};
      8'h28:   r = {1'b1, KIND_LPAREN};
      8'h29:   r = {1'b1, KIND_RPAREN};
      8'h7B:   r = {1'b1, KIND_LBRACE};
      8'h7D:   r = {1'b1, KIND_RBRACE};
      default: r = {1'b0, KIND_IDENT};
    endcase
    return r;
  endfunction

endpackage

### src/sll_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer scanner
// Scan state registers and the per-byte classification that yields tokens.
// ----------------------------------------------------------------------------
module sll_scanner #(
  parameter int COLUMN_LIMIT       = sll_pkg::COLUMN_LIMIT_DEF,
  parameter int TOKEN_LENGTH_LIMIT = sll_pkg::TOKEN_LENGTH_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  sll_pkg::text_beat_t   beat,
  output sll_pkg::scan_result_t result,
  output logic [2:0]            mode_out
);
  import sll_pkg::*;

  localparam int COL_CAP_I = (COLUMN_LIMIT - 1 > 16383) ? 16383 : COLUMN_LIMIT - 1;
  localparam int COL_W     = $clog2(COL_CAP_I + 1);
  localparam int RL_W      = $clog2(TOKEN_LENGTH_LIMIT + 1);
  localparam logic [COL_W-1:0] COL_CAP  = COL_W'(COL_CAP_I);
  localparam logic [RL_W-1:0]  RL_LIMIT = RL_W'(TOKEN_LENGTH_LIMIT);
  localparam logic [RL_W-1:0]  KW_MAX   = RL_W'(6);

  logic [2:0]       scan_mode, scan_mode_next;
  logic [47:0]      keyword_buffer, keyword_buffer_next;
  logic             letters_only, letters_only_next;
  logic [COL_W-1:0] token_start, token_start_next;
  logic [RL_W-1:0]  run_length, run_length_next;
  logic [15:0]      current_line, current_line_next;
  logic [COL_W-1:0] current_column, current_column_next;

  logic [7:0]       c;
  logic             taken;
  logic [5:0]       kw_hit;
  logic [5:0]       sym_hit;
  logic [4:0]       word_kind;
  logic             va, vb;
  token_beat_t      ta, tb;

  assign c        = beat.text_byte;
  assign kw_hit   = kw_lookup(keyword_buffer, run_length[2:0]);
  assign sym_hit  = sym_lookup(c);
  assign mode_out = scan_mode;

  // Kind of the pending word
  always_comb begin
    if (!letters_only || run_length > KW_MAX) word_kind = KIND_IDENT;
    else if (kw_hit[5]) word_kind = kw_hit[4:0];
    else word_kind = KIND_IDENT;
  end

  // Next state and tokens for one beat
  always_comb begin
    scan_mode_next      = scan_mode;
    keyword_buffer_next = keyword_buffer;
    letters_only_next   = letters_only;
    token_start_next    = token_start;
    run_length_next     = run_length;
    current_line_next   = current_line;
    current_column_next = current_column;
    taken = 1'b0;
    va = 1'b0;
    vb = 1'b0;
    ta = '0;
    tb = '0;
    ta.line_number  = current_line;
    tb.line_number  = current_line;
    ta.start_column = 14'(token_start);
    ta.token_length = 6'(run_length);
    tb.start_column = 14'(current_column);
    tb.token_length = 6'd1;

    if (beat.end_of_text) begin
      // Flush a pending run, then back to reset state
      if (scan_mode == MODE_WORD) begin
        va = 1'b1;
        ta.token_kind = word_kind;
      end else if (scan_mode == MODE_NUMBER) begin
        va = 1'b1;
        ta.token_kind = KIND_NUMBER;
      end
      scan_mode_next      = MODE_IDLE;
      keyword_buffer_next = '0;
      letters_only_next   = 1'b1;
      token_start_next    = '0;
      run_length_next     = '0;
      current_line_next   = 16'd1;
      current_column_next = '0;
    end else begin
      // Continue the pending token
      case (scan_mode)
        MODE_WORD, MODE_NUMBER: begin
          if ((scan_mode == MODE_WORD) ? is_word_char(c) : is_digit_char(c)) begin
            taken = 1'b1;
            if (run_length < KW_MAX)
              keyword_buffer_next = keyword_buffer | (48'(c) << {run_length[2:0], 3'b000});
            if (c == CH_UNDER) letters_only_next = 1'b0;
            if (run_length < RL_LIMIT) run_length_next = run_length + RL_W'(1);
          end else begin
            va = 1'b1;
            ta.token_kind = (scan_mode == MODE_WORD) ? word_kind : KIND_NUMBER;
            scan_mode_next = MODE_IDLE;
          end
        end
        MODE_COLON: begin
          scan_mode_next = MODE_IDLE;
          if (c == CH_EQUAL) begin
            taken = 1'b1;
            va = 1'b1;
            ta.token_kind   = KIND_ASSIGN;
            ta.token_length = 6'd2;
          end
        end
        MODE_COMMENT: begin
          taken = 1'b1;
          if (c == CH_RBRACE) begin
            va = 1'b1;
            ta.token_kind   = KIND_RBRACE;
            ta.start_column = 14'(current_column);
            ta.token_length = 6'd1;
            scan_mode_next  = MODE_IDLE;
          end
        end
        default: scan_mode_next = MODE_IDLE;
      endcase

      // Start a new token from this byte
      if (!taken) begin
        if (is_word_char(c) || is_digit_char(c)) begin
          scan_mode_next      = is_digit_char(c) ? MODE_NUMBER : MODE_WORD;
          keyword_buffer_next = {40'd0, c};
          letters_only_next   = (c != CH_UNDER);
          run_length_next     = RL_W'(1);
          token_start_next    = current_column;
        end else if (c == CH_COLON) begin
          scan_mode_next   = MODE_COLON;
          token_start_next = current_column;
          run_length_next  = RL_W'(1);
        end else if (sym_hit[5]) begin
          vb = 1'b1;
          tb.token_kind = sym_hit[4:0];
          if (sym_hit[4:0] == KIND_LBRACE) scan_mode_next = MODE_COMMENT;
        end
      end

      // Position of the next byte
      if (c == CH_NEWLINE) begin
        if (current_line != 16'hFFFF) current_line_next = current_line + 16'd1;
        current_column_next = '0;
      end else if (current_column < COL_CAP) begin
        current_column_next = current_column + COL_W'(1);
      end
    end

    ta.run_end = !vb;
    tb.run_end = 1'b1;
    result.valid_a = va && accept;
    result.valid_b = vb && accept;
    result.beat_a  = ta;
    result.beat_b  = tb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_IDLE;
      keyword_buffer <= '0;
      letters_only   <= 1'b1;
      token_start    <= '0;
      run_length     <= '0;
      current_line   <= 16'd1;
      current_column <= '0;
    end else if (accept) begin
      scan_mode      <= scan_mode_next;
      keyword_buffer <= keyword_buffer_next;
      letters_only   <= letters_only_next;
      token_start    <= token_start_next;
      run_length     <= run_length_next;
      current_line   <= current_line_next;
      current_column <= current_column_next;
    end
  end

endmodule

### src/sll_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token queue
// Four-entry token queue, up to two writes and one read a cycle.
// ----------------------------------------------------------------------------
module sll_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  sll_pkg::scan_result_t  result,
  input  logic                   token_stall,
  output logic                   token_valid,
  output sll_pkg::token_beat_t   token_beat,
  output sll_pkg::queue_status_t status
);
  import sll_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  token_beat_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr, wr_ptr;
  logic [FILL_W-1:0] fill, fill_next;
  logic [1:0]        push;
  logic              pop;
  logic [PTR_W-1:0]  wr_b;

  assign push        = {1'b0, result.valid_a} + {1'b0, result.valid_b};
  assign pop         = (fill != '0) && !token_stall;
  assign wr_b        = wr_ptr + PTR_W'(result.valid_a);
  assign fill_next   = fill + FILL_W'(push) - FILL_W'(pop);
  assign token_valid = (fill != '0);
  assign token_beat  = entries[rd_ptr];
  assign status.fill = 3'(fill);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      rd_ptr <= rd_ptr + PTR_W'(pop);
      wr_ptr <= wr_ptr + PTR_W'(push);
      fill   <= fill_next;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (result.valid_a) entries[wr_ptr] <= result.beat_a;
    if (result.valid_b) entries[wr_b] <= result.beat_b;
  end

endmodule

### src/small_language_lexer_top.sv
`timescale 1ns / 1ps
// A token is written into the token queue when the text beat that ends it is
// accepted, and is offered from there. One text beat per cycle while text_stall
// is low; a beat yielding two tokens puts both into the four-entry token queue.
// Input stalls while the queue lacks room for two tokens.
// Reset (rst, synchronous): line 1, column 0, idle scan, empty queue.
// ----------------------------------------------------------------------------
// Small language lexer
// Streams source bytes in and emits keyword, symbol, identifier and number
// tokens with line, column and length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module small_language_lexer_top #(
  parameter int COLUMN_LIMIT       = sll_pkg::COLUMN_LIMIT_DEF,
  parameter int TOKEN_LENGTH_LIMIT = sll_pkg::TOKEN_LENGTH_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  sll_pkg::text_beat_t  text_beat,
  output logic                 token_valid,
  input  logic                 token_stall,
  output sll_pkg::token_beat_t token_beat
);
  import sll_pkg::*;

  localparam logic [2:0] FILL_MAX = 3'(QUEUE_DEPTH);
  localparam logic [2:0] FILL_ACC = 3'(QUEUE_DEPTH - 2);

  logic          accept;
  scan_result_t  result;
  queue_status_t q_status;
  logic [2:0]    scan_mode;

  assign text_stall = q_status.fill > FILL_ACC;
  assign accept     = text_valid && !text_stall;

  sll_scanner #(
    .COLUMN_LIMIT      (COLUMN_LIMIT),
    .TOKEN_LENGTH_LIMIT(TOKEN_LENGTH_LIMIT)
  ) u_scanner (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .beat    (text_beat),
    .result  (result),
    .mode_out(scan_mode)
  );

  sll_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .token_stall(token_stall),
    .token_valid(token_valid),
    .token_beat (token_beat),
    .status     (q_status)
  );

  // Checks
  `ASSERT_NEVER(a_fill_bound, clk, rst, q_status.fill > FILL_MAX, "token queue overflow")
  `ASSERT_HOLDS(a_eot_idle, clk, rst, accept && text_beat.end_of_text |=> scan_mode == MODE_IDLE, "scan not idle after end of text")
  `ASSERT_NEVER(a_push_full, clk, rst, (result.valid_a || result.valid_b) && !accept, "token pushed without a text beat")

endmodule

### tb/small_language_lexer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small language lexer testbench
// Streams directed and random source text into the lexer and checks every
// token beat against a scanner model kept in step with the accepted text
// beats. Both sides idle at random, the token side holds off once long enough
// to back the lexer up, and end-of-text flushes are spread through the stream.
// ----------------------------------------------------------------------------
module small_language_lexer_top_test;
  import sll_pkg::*;

  // Keyword kinds, in token code order
  typedef enum logic [4:0] {
    KW_IF, KW_THEN, KW_ELSE, KW_END, KW_REPEAT, KW_UNTIL, KW_READ, KW_WRITE
  } keyword_kind_e;

  // Keyword spellings, first letter in the high byte
  localparam logic [47:0] WORD_IF     = "if";
  localparam logic [47:0] WORD_THEN   = "then";
  localparam logic [47:0] WORD_ELSE   = "else";
  localparam logic [47:0] WORD_END    = "end";
  localparam logic [47:0] WORD_REPEAT = "repeat";
  localparam logic [47:0] WORD_UNTIL  = "until";
  localparam logic [47:0] WORD_READ   = "read";
  localparam logic [47:0] WORD_WRITE  = "write";

  localparam int COL_CAP  = (COLUMN_LIMIT_DEF - 1 > 16383) ? 16383 : COLUMN_LIMIT_DEF - 1;
  localparam int LEN_CAP  = TOKEN_LENGTH_LIMIT_DEF;
  localparam int HOLD_LEN = 200;

  logic        clk;
  logic        rst         = 1'b1;
  logic        text_valid  = 1'b0;
  logic        text_stall;
  text_beat_t  text_beat   = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_beat_t token_beat;

  small_language_lexer_top dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_beat   (text_beat),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_beat  (token_beat)
  );

  // Source text waiting to go out, tokens the scanner says are still due
  text_beat_t  pending_text[$];
  token_beat_t scanned_tokens[$];

  int          beats_in    = 0;
  int          tokens_out  = 0;
  int          mismatches  = 0;
  int          swap_at     = 0;
  int          calm_at     = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  logic [31:0] kinds_seen  = '0;

  // Scanner state
  logic [2:0]  scan_state;
  logic [47:0] word_text;
  logic        pure_letters;
  logic [13:0] run_col;
  logic [5:0]  run_len;
  logic [15:0] cur_line;
  logic [13:0] cur_col;

  // Tokens produced by the beat being scanned
  token_beat_t step_buf[2];
  int          step_n;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------
  function automatic logic word_byte_ok(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic digit_byte_ok(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Single-byte symbols; anything else comes back as identifier (no symbol)
  function automatic logic [4:0] symbol_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      "=":       k = KIND_EQ;
      "<":       k = KIND_LT;
      "+":       k = KIND_PLUS;
      "-":       k = KIND_MINUS;
      "*":       k = KIND_STAR;
      "/":       k = KIND_SLASH;
      "^":       k = KIND_CARET;
      ";":       k = KIND_SEMI;
      "(":       k = KIND_LPAREN;
      ")":       k = KIND_RPAREN;
      "{":       k = KIND_LBRACE;
      "}":       k = KIND_RBRACE;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] word_kind();
    logic [4:0] k;
    k = KIND_IDENT;
    if (pure_letters && run_len <= 6) begin
      case (word_text)
        WORD_IF:     k = KW_IF;
        WORD_THEN:   k = KW_THEN;
        WORD_ELSE:   k = KW_ELSE;
        WORD_END:    k = KW_END;
        WORD_REPEAT: k = KW_REPEAT;
        WORD_UNTIL:  k = KW_UNTIL;
        WORD_READ:   k = KW_READ;
        WORD_WRITE:  k = KW_WRITE;
        default:     k = KIND_IDENT;
      endcase
    end
    return k;
  endfunction

  task automatic clear_scan();
    scan_state   = MODE_IDLE;
    word_text    = '0;
    pure_letters = 1'b1;
    run_col      = '0;
    run_len      = '0;
    cur_line     = 16'd1;
    cur_col      = '0;
  endtask

  task automatic push_token(input logic [4:0] kind, input logic [13:0] col,
                            input logic [5:0] len);
    if (step_n < 2) begin
      step_buf[step_n].token_kind   = kind;
      step_buf[step_n].line_number  = cur_line;
      step_buf[step_n].start_column = col;
      step_buf[step_n].token_length = len;
      step_buf[step_n].run_end      = 1'b0;
      step_n++;
    end
  endtask

  task automatic flush_run();
    if (scan_state == MODE_WORD)
      push_token(word_kind(), run_col, run_len);
    else if (scan_state == MODE_NUMBER)
      push_token(KIND_NUMBER, run_col, run_len);
    scan_state = MODE_IDLE;
  endtask

  task automatic grow_run(input logic [7:0] c);
    if (run_len < 6)
      word_text = {word_text[39:0], c};
    if (c == CH_UNDER)
      pure_letters = 1'b0;
    if (run_len < LEN_CAP)
      run_len++;
  endtask

  task automatic open_run(input logic [2:0] mode, input logic [7:0] c);
    scan_state   = mode;
    word_text    = '0;
    pure_letters = 1'b1;
    run_len      = '0;
    run_col      = cur_col;
    grow_run(c);
  endtask

  // Advance the scanner by one accepted text beat
  task automatic scan_text_beat(input text_beat_t b);
    logic [7:0] c;
    logic       taken;
    logic [4:0] sk;
    c      = b.text_byte;
    taken  = 1'b0;
    step_n = 0;
    if (b.end_of_text) begin
      flush_run();
      clear_scan();
    end else begin
      case (scan_state)
        MODE_WORD: begin
          if (word_byte_ok(c)) begin
            grow_run(c);
            taken = 1'b1;
          end else flush_run();
        end
        MODE_NUMBER: begin
          if (digit_byte_ok(c)) begin
            grow_run(c);
            taken = 1'b1;
          end else flush_run();
        end
        MODE_COLON: begin
          scan_state = MODE_IDLE;
          if (c == CH_EQUAL) begin
            push_token(KIND_ASSIGN, run_col, 6'd2);
            taken = 1'b1;
          end
        end
        MODE_COMMENT: begin
          taken = 1'b1;
          if (c == CH_RBRACE) begin
            push_token(KIND_RBRACE, cur_col, 6'd1);
            scan_state = MODE_IDLE;
          end
        end
        default: scan_state = MODE_IDLE;
      endcase
      // byte not consumed by the pending token starts something new
      if (!taken) begin
        if (word_byte_ok(c)) open_run(MODE_WORD, c);
        else if (digit_byte_ok(c)) open_run(MODE_NUMBER, c);
        else if (c == CH_COLON) begin
          scan_state = MODE_COLON;
          run_col    = cur_col;
          run_len    = 6'd1;
        end else begin
          sk = symbol_kind(c);
          if (sk != KIND_IDENT) begin
            push_token(sk, cur_col, 6'd1);
            if (sk == KIND_LBRACE)
              scan_state = MODE_COMMENT;
          end
        end
      end
      // position of the next byte
      if (c == CH_NEWLINE) begin
        if (cur_line != 16'hFFFF)
          cur_line++;
        cur_col = '0;
      end else if (cur_col < COL_CAP) begin
        cur_col++;
      end
    end
    if (step_n > 0)
      step_buf[step_n - 1].run_end = 1'b1;
    for (int i = 0; i < step_n; i++)
      scanned_tokens.push_back(step_buf[i]);
  endtask

  // --------------------------------------------------------------------------
  // Source text generation
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c);
    text_beat_t b;
    b.text_byte   = c;
    b.end_of_text = 1'b0;
    pending_text.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
  endtask

  task automatic add_end();
    text_beat_t b;
    b.text_byte   = 8'($urandom_range(255));
    b.end_of_text = 1'b1;
    pending_text.push_back(b);
  endtask

  function automatic string keyword_text(int k);
    case (k)
      0:       return "if";
      1:       return "then";
      2:       return "else";
      3:       return "end";
      4:       return "repeat";
      5:       return "until";
      6:       return "read";
      default: return "write";
    endcase
  endfunction

  function automatic logic [7:0] rand_word_byte();
    case ($urandom_range(6))
      0:       return CH_UNDER;
      1, 2:    return 8'("A" + $urandom_range(25));
      default: return 8'("a" + $urandom_range(25));
    endcase
  endfunction

  // Mostly well-formed pieces of source with random content, some noise
  task automatic add_fragment();
    int         pick;
    int         n;
    logic [7:0] c;
    string      syms;
    string      gaps;
    syms = "=<+-*/^;()";
    gaps = " \t\r\n";
    pick = $urandom_range(99);
    if (pick < 20) begin
      add_text(keyword_text($urandom_range(7)));
    end else if (pick < 25) begin
      // near miss on a keyword
      add_text(keyword_text($urandom_range(7)));
      add_byte(rand_word_byte());
    end else if (pick < 40) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        add_byte(rand_word_byte());
    end else if (pick < 52) begin
      n = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        add_byte(8'("0" + $urandom_range(9)));
    end else if (pick < 72) begin
      add_byte(syms[$urandom_range(syms.len() - 1)]);
    end else if (pick < 77) begin
      add_text(":=");
    end else if (pick < 80) begin
      add_byte(CH_COLON);
    end else if (pick < 86) begin
      // comment body may hold newlines, opening braces and any other byte
      add_byte("{");
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(255));
        if (c == CH_RBRACE)
          c = CH_NEWLINE;
        add_byte(c);
      end
      if ($urandom_range(9) != 0)
        add_byte(CH_RBRACE);
    end else if (pick < 97) begin
      add_byte(gaps[$urandom_range(3)]);
    end else if (pick < 99) begin
      add_byte(8'($urandom_range(255)));
    end else begin
      add_end();
    end
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting and token check
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_token(input token_beat_t got);
    token_beat_t want;
    tokens_out++;
    kinds_seen[got.token_kind] = 1'b1;
    if (scanned_tokens.size() == 0) begin
      report_mismatch("token kind with no token due", got.token_kind, -1);
    end else begin
      want = scanned_tokens.pop_front();
      if (got.token_kind != want.token_kind)
        report_mismatch("token_kind", got.token_kind, want.token_kind);
      if (got.line_number != want.line_number)
        report_mismatch("line_number", got.line_number, want.line_number);
      if (got.start_column != want.start_column)
        report_mismatch("start_column", got.start_column, want.start_column);
      if (got.token_length != want.token_length)
        report_mismatch("token_length", got.token_length, want.token_length);
      if (got.run_end != want.run_end)
        report_mismatch("run_end", got.run_end, want.run_end);
    end
  endtask

  // Idle rates: sender-light first, then receiver-light, then none
  function automatic int sender_idle_pct();
    if (beats_in < swap_at) return 32;
    if (beats_in < calm_at) return 65;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (beats_in < swap_at) return 65;
    if (beats_in < calm_at) return 32;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Text side driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        scan_text_beat(text_beat);
        beats_in <= beats_in + 1;
      end
      if (!text_valid || !text_stall) begin
        if (pending_text.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          text_beat  <= pending_text.pop_front();
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long token-side hold-off once the idle-free part begins
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && beats_in >= calm_at) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Token side monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (token_valid && !token_stall)
        check_token(token_beat);
      token_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    clear_scan();

    // directed: word with underscore, assign, number, lone colon, comment
    // spanning lines with a brace inside, odd bytes, flush on end of text
    add_text("x_1:=0");
    add_text(": ;");
    add_text("{a{\n}");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("\r\t");
    add_text("then");
    add_end();
    add_text("9");
    add_end();

    // random source text in three idling phases
    while (pending_text.size() < 160) add_fragment();
    swap_at = pending_text.size();
    while (pending_text.size() < 320) add_fragment();
    calm_at = pending_text.size();
    while (pending_text.size() < 485) add_fragment();
    add_end();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_text.size() != 0 || text_valid) @(posedge clk);
    while (scanned_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d text beats (directed cases, random text, comments, noise),",
             beats_in);
    $display("checked %0d tokens covering %0d of 23 token kinds.",
             tokens_out, $countones(kinds_seen));
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Timed out with %0d tokens still due", scanned_tokens.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
